>>> sv/dna_pkg.sv
`default_nettype none

package dna_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QBITS         = 32;
	localparam int DIV_LAT       = QBITS + 1;
	localparam int Q_DEPTH       = 4;

	localparam logic [2:0] KIND_NEG   = 3'd0;
	localparam logic [2:0] KIND_ADD   = 3'd1;
	localparam logic [2:0] KIND_SUB   = 3'd2;
	localparam logic [2:0] KIND_MUL   = 3'd3;
	localparam logic [2:0] KIND_DIV   = 3'd4;
	localparam logic [2:0] KIND_SCALE = 3'd5;
	localparam logic [2:0] KIND_DIVF  = 3'd6;

	typedef struct packed {
		logic [2:0]         kind;
		logic               err;
		logic signed [31:0] ar;
		logic signed [31:0] ad;
		logic signed [31:0] br;
		logic signed [31:0] bd;
		logic signed [31:0] f;
		logic signed [63:0] pa;
		logic signed [63:0] pb;
		logic signed [63:0] pc;
		logic [63:0]        pd;
	} item_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] m;
		logic [63:0] den;
	} div_in_t;

	typedef struct packed {
		logic        ok;
		logic        use_div;
		logic [31:0] rr;
		logic [31:0] rd;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		logic [31:0] r;
		if (v > 65'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -65'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] abs32(input logic signed [31:0] v);
		logic signed [64:0] w;
		w = 65'(v);
		if (v < 0)
			w = -w;
		return w[63:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/dna_front.sv
`default_nettype none

module dna_front
	import dna_pkg::*;
(
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] a_real,
	input  wire logic signed [31:0] a_dual,
	input  wire logic signed [31:0] b_real,
	input  wire logic signed [31:0] b_dual,
	input  wire logic signed [31:0] factor,
	output item_t                   item
);

	logic signed [31:0] sel;

	always_comb begin
		sel = (kind == KIND_SCALE) ? factor : b_real;
		item.kind = kind;
		item.ar   = a_real;
		item.ad   = a_dual;
		item.br   = b_real;
		item.bd   = b_dual;
		item.f    = factor;
		item.pa   = 64'(a_real) * 64'(sel);
		item.pb   = 64'(a_real) * 64'(b_dual);
		item.pc   = 64'(a_dual) * 64'(sel);
		item.pd   = 64'(64'(b_real) * 64'(b_real));
		case (kind)
			KIND_NEG, KIND_ADD, KIND_SUB, KIND_MUL, KIND_SCALE: item.err = 1'b0;
			KIND_DIV:  item.err = (b_real == 32'sd0);
			KIND_DIVF: item.err = (factor == 32'sd0);
			default:   item.err = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/dna_queue.sv
`default_nettype none

module dna_queue
	import dna_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  item_t      wr_item,
	output logic       full,
	input  wire logic  rd,
	output item_t      rd_item,
	output logic       empty
);

	localparam int PW = $clog2(Q_DEPTH);

	item_t          ent_q [Q_DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [PW:0]    cnt_q;

	assign full    = (cnt_q == (PW+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> sv/dna_div.sv
`default_nettype none

module dna_div
	import dna_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic en,
	input  div_in_t   din,
	output logic [31:0] res
);

	localparam int W = 64 + FRAC_BITS + 33;

	logic [W-1:0]       rem_q [QBITS+1];
	logic [63:0]        den_q [QBITS+1];
	logic [QBITS-1:0]   quo_q [QBITS+1];
	logic               neg_q [QBITS+1];
	logic               big_q [QBITS+1];

	logic [W-1:0] n_in;
	logic [W-1:0] d_top;

	assign n_in  = W'(din.m) << FRAC_BITS;
	assign d_top = W'(din.den) << QBITS;

	// quotient would exceed 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= n_in;
			den_q[0] <= din.den;
			quo_q[0] <= '0;
			neg_q[0] <= din.neg;
			big_q[0] <= (n_in >= d_top);
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		localparam int SH = QBITS - k;
		logic [W-1:0] t;
		logic         ge;
		assign t  = W'(den_q[k-1]) << SH;
		assign ge = (rem_q[k-1] >= t);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_q[k-1] - t : rem_q[k-1];
				den_q[k] <= den_q[k-1];
				quo_q[k] <= {quo_q[k-1][QBITS-2:0], ge};
				neg_q[k] <= neg_q[k-1];
				big_q[k] <= big_q[k-1];
			end
		end
	end

	always_comb begin
		if (!neg_q[QBITS]) begin
			if (big_q[QBITS] || quo_q[QBITS][31])
				res = 32'h7FFF_FFFF;
			else
				res = quo_q[QBITS];
		end else begin
			if (big_q[QBITS] || (quo_q[QBITS] > 32'h8000_0000))
				res = 32'h8000_0000;
			else
				res = 32'd0 - quo_q[QBITS];
		end
	end

endmodule

`default_nettype wire

>>> sv/dna_back.sv
`default_nettype none

module dna_back
	import dna_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  item_t             head,
	output logic              q_pop,
	output logic              empty,
	input  wire logic         pop,
	output logic signed [31:0] res_real,
	output logic signed [31:0] res_dual,
	output logic              ok
);

	logic    en;
	side_t   side_c;
	div_in_t dre_c;
	div_in_t ddu_c;

	logic    vld_s1;
	side_t   side_s1;
	div_in_t dre_s1;
	div_in_t ddu_s1;

	logic    vld_q [DIV_LAT];
	side_t   side_q [DIV_LAT];

	logic [31:0] qre;
	logic [31:0] qdu;

	logic        out_vld_q;
	logic [31:0] rr_q;
	logic [31:0] rd_q;
	logic        ok_q;

	assign en    = !out_vld_q || pop;
	assign q_pop = en && !q_empty;

	always_comb begin
		logic signed [64:0] diff;
		logic               dneg;
		logic signed [64:0] dmag;
		diff = 65'(head.pc) - 65'(head.pb);
		dneg = diff[64];
		dmag = dneg ? -diff : diff;

		side_c.ok      = !head.err;
		side_c.use_div = 1'b0;
		side_c.rr      = '0;
		side_c.rd      = '0;
		dre_c.neg = head.ar[31] ^ head.f[31];
		dre_c.m   = abs32(head.ar);
		dre_c.den = abs32(head.f);
		ddu_c.neg = head.ad[31] ^ head.f[31];
		ddu_c.m   = abs32(head.ad);
		ddu_c.den = abs32(head.f);
		case (head.kind)
			KIND_NEG: begin
				side_c.rr = sat32(65'sd0 - 65'(head.ar));
				side_c.rd = sat32(65'sd0 - 65'(head.ad));
			end
			KIND_ADD: begin
				side_c.rr = sat32(65'(head.ar) + 65'(head.br));
				side_c.rd = sat32(65'(head.ad) + 65'(head.bd));
			end
			default: ;
		endcase
		// remaining kinds
		case (head.kind)
			KIND_SUB: begin
				side_c.rr = sat32(65'(head.ar) - 65'(head.br));
				side_c.rd = sat32(65'(head.ad) - 65'(head.bd));
			end
			KIND_MUL, KIND_SCALE: begin
				side_c.rr = sat32(65'(head.pa) >>> FRAC_BITS);
				if (head.kind == KIND_MUL)
					side_c.rd = sat32((65'(head.pb) + 65'(head.pc)) >>> FRAC_BITS);
				else
					side_c.rd = sat32(65'(head.pc) >>> FRAC_BITS);
			end
			KIND_DIV: begin
				side_c.use_div = !head.err;
				dre_c.neg = head.ar[31] ^ head.br[31];
				dre_c.den = abs32(head.br);
				ddu_c.neg = dneg;
				ddu_c.m   = dmag[63:0];
				ddu_c.den = head.pd;
			end
			KIND_DIVF: begin
				side_c.use_div = !head.err;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= !q_empty;
			out_vld_q <= vld_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			dre_s1  <= dre_c;
			ddu_s1  <= ddu_c;
		end
	end

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k] <= 1'b0;
			else if (en)
				vld_q[k] <= (k == 0) ? vld_s1 : vld_q[(k == 0) ? 0 : k-1];
		end
		always_ff @(posedge clk) begin
			if (en)
				side_q[k] <= (k == 0) ? side_s1 : side_q[(k == 0) ? 0 : k-1];
		end
	end

	dna_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk (clk),
		.en  (en),
		.din (dre_s1),
		.res (qre)
	);

	dna_div #(.FRAC_BITS(FRAC_BITS)) u_div_du (
		.clk (clk),
		.en  (en),
		.din (ddu_s1),
		.res (qdu)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q <= side_q[DIV_LAT-1].ok;
			if (!side_q[DIV_LAT-1].ok) begin
				rr_q <= '0;
				rd_q <= '0;
			end else if (side_q[DIV_LAT-1].use_div) begin
				rr_q <= qre;
				rd_q <= qdu;
			end else begin
				rr_q <= side_q[DIV_LAT-1].rr;
				rd_q <= side_q[DIV_LAT-1].rd;
			end
		end
	end

	assign empty    = !out_vld_q;
	assign res_real = rr_q;
	assign res_dual = rd_q;
	assign ok       = ok_q;

endmodule

`default_nettype wire

>>> sv/dual_number_alu.sv
// Dual number arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Input side is a queue write port: a beat is taken at a clock edge with push
// high and full low. Each beat carries kind and the operands a, b and factor.
// Result side is a queue read port: while empty is low the oldest result is on
// res_real, res_dual and ok; it is taken at an edge with pop high.
// One result per input beat, in order. ok low means division by zero or an
// unused kind, with both parts zero; other results saturate to 32 bits.
// Throughput: one beat per cycle in both directions while pop is high. A
// beat passes the front queue, the operand registers, the 33 register
// steps of the restoring dividers (an overflow check, then one quotient
// bit per step) and the output register. Products are formed as the beat
// is taken and held in a four-entry queue ahead of the arithmetic pipeline.
// When pop is held low while a result waits, the output register keeps it and
// the whole pipeline holds; the front queue then fills as beats arrive and full rises.
// Reset clears the queue pointers and all valid flags; nothing is pending
// afterwards and empty is high.
`default_nettype none

module dual_number_alu
	import dna_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] a_real,
	input  wire logic signed [31:0] a_dual,
	input  wire logic signed [31:0] b_real,
	input  wire logic signed [31:0] b_dual,
	input  wire logic signed [31:0] factor,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      res_real,
	output logic signed [31:0]      res_dual,
	output logic                    ok
);

	item_t in_item;
	item_t head;
	logic  q_empty;
	logic  q_pop;

	dna_front u_front (
		.kind   (kind),
		.a_real (a_real),
		.a_dual (a_dual),
		.b_real (b_real),
		.b_dual (b_dual),
		.factor (factor),
		.item   (in_item)
	);

	dna_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push && !full),
		.wr_item (in_item),
		.full    (full),
		.rd      (q_pop),
		.rd_item (head),
		.empty   (q_empty)
	);

	dna_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.res_real (res_real),
		.res_dual (res_dual),
		.ok       (ok)
	);

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !ok |-> res_real == 32'sd0 && res_dual == 32'sd0)
		else $error("error result with non-zero parts");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !q_empty)
		else $error("front queue full yet empty");

	a_stall_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |-> !q_pop)
		else $error("queue drained while output stalled");
`endif

endmodule

`default_nettype wire

>>> verif/tb_dual_number_alu.sv
`timescale 1ns / 100ps

module tb_dual_number_alu;
	import dna_pkg::*;

	typedef struct {
		logic [31:0] res_real;
		logic [31:0] res_dual;
		logic        ok;
	} dual_result_t;

	localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int FB = FRAC_BITS_DEF;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         kind;
	logic signed [31:0] a_real;
	logic signed [31:0] a_dual;
	logic signed [31:0] b_real;
	logic signed [31:0] b_dual;
	logic signed [31:0] factor;
	logic               empty;
	logic               pop;
	logic signed [31:0] res_real;
	logic signed [31:0] res_dual;
	logic               ok;

	dual_result_t awaited_results[$];
	int  mismatches = 0;
	bit  steady     = 0;

	dual_number_alu i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.kind    (kind),
		.a_real  (a_real),
		.a_dual  (a_dual),
		.b_real  (b_real),
		.b_dual  (b_dual),
		.factor  (factor),
		.empty   (empty),
		.pop     (pop),
		.res_real(res_real),
		.res_dual(res_dual),
		.ok      (ok)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [31:0] clamp_q(input logic signed [127:0] v);
		if (v > Q_MAX)
			return 32'h7FFF_FFFF;
		if (v < Q_MIN)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic dual_result_t dual_alu_predict(input logic [2:0] k,
			input logic signed [31:0] ar32, input logic signed [31:0] ad32,
			input logic signed [31:0] br32, input logic signed [31:0] bd32,
			input logic signed [31:0] f32);
		logic signed [127:0] ar, ad, br, bd, f, num;
		dual_result_t r;
		ar = ar32;
		ad = ad32;
		br = br32;
		bd = bd32;
		f  = f32;
		r.ok = 1'b1;
		r.res_real = '0;
		r.res_dual = '0;
		case (k)
			KIND_NEG: begin
				r.res_real = clamp_q(-ar);
				r.res_dual = clamp_q(-ad);
			end
			KIND_ADD: begin
				r.res_real = clamp_q(ar + br);
				r.res_dual = clamp_q(ad + bd);
			end
			KIND_SUB: begin
				r.res_real = clamp_q(ar - br);
				r.res_dual = clamp_q(ad - bd);
			end
			KIND_MUL: begin
				r.res_real = clamp_q((ar * br) >>> FB);
				r.res_dual = clamp_q((ar * bd + ad * br) >>> FB);
			end
			KIND_DIV: begin
				if (br == 0) begin
					r.ok = 1'b0;
				end else begin
					r.res_real = clamp_q((ar <<< FB) / br);
					num = ad * br - ar * bd;
					r.res_dual = clamp_q((num <<< FB) / (br * br));
				end
			end
			KIND_SCALE: begin
				r.res_real = clamp_q((ar * f) >>> FB);
				r.res_dual = clamp_q((ad * f) >>> FB);
			end
			KIND_DIVF: begin
				if (f == 0) begin
					r.ok = 1'b0;
				end else begin
					r.res_real = clamp_q((ar <<< FB) / f);
					r.res_dual = clamp_q((ad <<< FB) / f);
				end
			end
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %h, want %h", $realtime, field, got, want);
		mismatches++;
	endtask

	// accepted beats on both sides
	always @(posedge clk) begin
		dual_result_t want;
		if (arst_n) begin
			if (push && !full)
				awaited_results.push_back(dual_alu_predict(kind, a_real, a_dual,
					b_real, b_dual, factor));
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected beat", {31'b0, ok}, 32'b0);
				end else begin
					want = awaited_results.pop_front();
					if (res_real !== want.res_real)
						report_mismatch("res_real", res_real, want.res_real);
					if (res_dual !== want.res_dual)
						report_mismatch("res_dual", res_dual, want.res_dual);
					if (ok !== want.ok)
						report_mismatch("ok", {31'b0, ok}, {31'b0, want.ok});
				end
			end
		end
	end

	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			pop <= steady || ($urandom_range(0, 99) >= 28);
		end
	end

	task automatic send_beat(input logic [2:0] k, input logic [31:0] ar,
			input logic [31:0] ad, input logic [31:0] br, input logic [31:0] bd,
			input logic [31:0] f);
		while (!steady && $urandom_range(0, 99) < 28) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push   <= 1'b1;
		kind   <= k;
		a_real <= ar;
		a_dual <= ad;
		b_real <= br;
		b_dual <= bd;
		factor <= f;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic drain_results;
		push <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_operand;
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 19) - (1 << 18);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'h0;
			4: return ($urandom_range(0, 64) - 32) << FB;
			5: return $urandom_range(0, 1 << 25) - (1 << 24);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_extremes;
		logic [31:0] edges [5];
		logic [2:0] k;
		edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0};
		for (int i = 0; i < 3; i++) begin
			k = KIND_NEG + 3'(i);
			send_beat(k, edges[i], edges[i + 1], edges[i + 1], edges[i], edges[i]);
		end
		send_beat(KIND_NEG, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
		send_beat(KIND_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_beat(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0, 0);
		send_beat(KIND_DIV, 32'h7FFF_FFFF, 32'h1234_5678, 32'h0000_0001, 32'h8000_0000, 0);
		send_beat(KIND_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 0);
		send_beat(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_beat(KIND_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0, 0);
		send_beat(KIND_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
		send_beat(KIND_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 32'h0000_8000);
		send_beat(KIND_DIVF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h0000_0001);
		send_beat(KIND_DIVF, 32'h0001_0000, 32'h0002_0000, 0, 0, 32'h0);
		send_beat(KIND_DIVF, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 32'h0003_0000);
		send_beat(KIND_UNUSED, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5);
		send_beat(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 0);
		send_beat(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 0);
		drain_results();
	endtask

	task automatic test_random_ops(input int count);
		logic [2:0] k;
		for (int n = 0; n < count; n++) begin
			k = ($urandom_range(0, 49) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 6));
			send_beat(k, pick_operand(), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
		end
	endtask

	initial begin
		arst_n = 0;
		push   = 0;
		kind   = '0;
		a_real = '0;
		a_dual = '0;
		b_real = '0;
		b_dual = '0;
		factor = '0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_extremes();
		test_random_ops(450);
		drain_results();
		steady = 1;
		test_random_ops(300);
		steady = 0;
		test_random_ops(400);
		drain_results();
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> dual_number_alu.f
sv/dna_pkg.sv
sv/dna_front.sv
sv/dna_queue.sv
sv/dna_div.sv
sv/dna_back.sv
sv/dual_number_alu.sv
verif/tb_dual_number_alu.sv
